[hdl/ptrp_pkg.sv]
// Shared types and constants for the position tag response parser.
`default_nettype none

package ptrp_pkg;

    localparam int unsigned SumLen = 20;           // bytes covered by the checksum
    localparam int unsigned StoreAw = 5;           // index bits for the byte store
    localparam int unsigned FifoDepth = 2;

    localparam int unsigned AngMod = 3600;         // one turn in 0.1 degree
    localparam int unsigned AngHalf = 1800;
    localparam int unsigned AngBias = 4 * AngMod;  // makes the corrected angle positive

    localparam int unsigned VW = 15;               // biased angle width
    localparam int unsigned RW = 12;               // angle remainder width

    localparam logic [StoreAw-1:0] C_SUM_LEN = StoreAw'(SumLen);
    localparam int unsigned DetBit = 6;            // tag present flag in byte 1

    // raw fields of one finished response, before the heading math
    typedef struct packed {
        logic        ok;
        logic        det;
        logic [23:0] pos_x;
        logic [13:0] pos_y;
        logic [13:0] ang;
        logic [23:0] tag;
    } t_frame;

endpackage

`default_nettype wire

[hdl/ptrp_front.sv]
// Byte counter, checksum and byte store; hands a finished response to the queue.
`default_nettype none

module ptrp_front (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_accept,
    input  wire  [7:0]           i_rx_byte,
    input  wire                  i_frame_start,
    output logic                 o_push,
    output ptrp_pkg::t_frame     o_frame
);
    import ptrp_pkg::*;

    logic [StoreAw-1:0] r_count, n_count;
    logic [7:0]         r_xor, n_xor;
    logic [7:0]         r_store [SumLen];

    logic [StoreAw-1:0] w_cnt;
    logic [7:0]         w_xor;
    logic               w_last;

    always_comb begin
        w_cnt  = i_frame_start ? '0 : r_count;
        w_xor  = i_frame_start ? '0 : r_xor;
        w_last = (w_cnt == C_SUM_LEN);
        n_count = r_count;
        n_xor   = r_xor;
        if (i_accept) begin
            if (w_last) begin
                n_count = '0;
                n_xor   = '0;
            end else begin
                n_count = w_cnt + StoreAw'(1);
                n_xor   = w_xor ^ i_rx_byte;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_xor   <= '0;
        end else begin
            r_count <= n_count;
            r_xor   <= n_xor;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept && !w_last) begin
            r_store[w_cnt] <= i_rx_byte;
        end
    end

    always_comb begin
        o_push        = i_accept && w_last;
        o_frame.ok    = (w_xor == i_rx_byte);
        o_frame.det   = o_frame.ok && r_store[1][DetBit];
        o_frame.pos_x = {r_store[2][2:0], r_store[3][6:0], r_store[4][6:0], r_store[5][6:0]};
        o_frame.pos_y = {r_store[6][6:0], r_store[7][6:0]};
        o_frame.ang   = {r_store[10][6:0], r_store[11][6:0]};
        o_frame.tag   = {r_store[14][2:0], r_store[15][6:0], r_store[16][6:0],
                         r_store[17][6:0]};
    end

endmodule

`default_nettype wire

[hdl/ptrp_fifo.sv]
// Short queue of finished responses between front and back.
`default_nettype none

module ptrp_fifo (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_push,
    input  ptrp_pkg::t_frame     i_frame,
    input  wire                  i_pop,
    output ptrp_pkg::t_frame     o_frame,
    output logic                 o_empty,
    output logic                 o_full
);
    import ptrp_pkg::*;

    localparam int unsigned PW = $clog2(FifoDepth);

    t_frame          r_mem [FifoDepth];
    logic [PW-1:0]   r_wp, r_rp;
    logic [PW:0]     r_cnt;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == (PW+1)'(FifoDepth));
    assign o_frame = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_frame;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PW'(FifoDepth - 1)) ? '0 : r_wp + PW'(1);
            end
            if (i_pop) begin
                r_rp <= (r_rp == PW'(FifoDepth - 1)) ? '0 : r_rp + PW'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + (PW+1)'(1);
                2'b01:   r_cnt <= r_cnt - (PW+1)'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

`default_nettype wire

[hdl/ptrp_back.sv]
// Heading correction pipeline and output register.
`default_nettype none

module ptrp_back (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_cfg_we,
    input  wire  [12:0]          i_cfg_data,
    input  ptrp_pkg::t_frame     i_frame,
    input  wire                  i_empty,
    output logic                 o_pop,
    output logic                 o_res_valid,
    input  wire                  i_res_stall,
    output logic                 o_checksum_ok,
    output logic                 o_tag_detected,
    output logic signed [23:0]   o_pos_x,
    output logic signed [13:0]   o_pos_y,
    output logic signed [11:0]   o_heading,
    output logic [23:0]          o_tag_number
);
    import ptrp_pkg::*;

    logic signed [12:0] r_offset;

    logic          r_a_valid, r_b_valid, r_o_valid;
    t_frame        r_a_frm, r_b_frm;
    logic [VW-1:0] r_a_v;
    logic [RW-1:0] r_b_r;

    logic          w_o_rdy, w_b_rdy, w_a_rdy;
    logic signed [15:0] w_v;
    logic [VW-1:0] w_sub;
    logic [VW-1:0] w_rem;
    logic [RW:0]   w_neg;
    logic [RW-1:0] w_hd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= '0;
        end else if (i_cfg_we) begin
            r_offset <= i_cfg_data;
        end
    end

    assign w_o_rdy = !r_o_valid || !i_res_stall;
    assign w_b_rdy = !r_b_valid || w_o_rdy;
    assign w_a_rdy = !r_a_valid || w_b_rdy;
    assign o_pop   = !i_empty && w_a_rdy;

    // angle minus offset, biased by four turns so it never goes negative
    assign w_v = 16'(signed'(i_frame.ang)) - 16'(r_offset) + 16'(AngBias);

    // reduce mod one turn: biased value is below eight turns
    always_comb begin
        w_sub = '0;
        for (int k = 1; k < 8; k++) begin
            if (r_a_v >= VW'(k * AngMod)) begin
                w_sub = VW'(k * AngMod);
            end
        end
        w_rem = r_a_v - w_sub;
    end

    always_comb begin
        w_neg = {1'b0, r_b_r} - (RW+1)'(AngMod);
        w_hd  = (r_b_r > RW'(AngHalf)) ? w_neg[RW-1:0] : r_b_r;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (w_a_rdy) r_a_valid <= !i_empty;
            if (w_b_rdy) r_b_valid <= r_a_valid;
            if (w_o_rdy) r_o_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_a_frm <= i_frame;
            r_a_v   <= w_v[VW-1:0];
        end
        if (w_b_rdy && r_a_valid) begin
            r_b_frm <= r_a_frm;
            r_b_r   <= w_rem[RW-1:0];
        end
        if (w_o_rdy && r_b_valid) begin
            o_checksum_ok  <= r_b_frm.ok;
            o_tag_detected <= r_b_frm.det;
            o_pos_x        <= r_b_frm.det ? r_b_frm.pos_x : '0;
            o_pos_y        <= r_b_frm.det ? r_b_frm.pos_y : '0;
            o_heading      <= r_b_frm.det ? w_hd : '0;
            o_tag_number   <= r_b_frm.det ? r_b_frm.tag : '0;
        end
    end

    assign o_res_valid = r_o_valid;

endmodule

`default_nettype wire

[hdl/position_tag_response_parser.sv]
// Top level of the position tag response parser.
//
//  channel | valid       | stall       | payload
//  --------+-------------+-------------+-----------------------------------------------
//  rx      | i_rx_valid  | o_rx_stall  | i_rx_byte, i_frame_start
//  result  | o_res_valid | i_res_stall | o_checksum_ok, o_tag_detected, o_pos_x,
//          |             |             | o_pos_y, o_heading, o_tag_number
//  config  | i_cfg_we    | -           | i_cfg_data (angle offset)
//
// One byte per cycle while o_rx_stall is low. Once its checksum byte is taken, a result
// goes through queue write, offset add, mod-turn reduce and wrap into output to o_res_valid.
// o_rx_stall rises only while the two-entry response queue is full.
// Synchronous active-low reset clears counts, checksum, queue and offset.
`default_nettype none

module position_tag_response_parser (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_rx_valid,
    output logic                 o_rx_stall,
    input  wire  [7:0]           i_rx_byte,
    input  wire                  i_frame_start,
    input  wire                  i_cfg_we,
    input  wire  [12:0]          i_cfg_data,
    output logic                 o_res_valid,
    input  wire                  i_res_stall,
    output logic                 o_checksum_ok,
    output logic                 o_tag_detected,
    output logic signed [23:0]   o_pos_x,
    output logic signed [13:0]   o_pos_y,
    output logic signed [11:0]   o_heading,
    output logic [23:0]          o_tag_number
);
    import ptrp_pkg::*;

    logic   w_accept, w_push, w_pop, w_empty, w_full;
    t_frame w_frm_in, w_frm_out;

    assign o_rx_stall = w_full;
    assign w_accept   = i_rx_valid && !w_full;

    ptrp_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (w_accept),
        .i_rx_byte     (i_rx_byte),
        .i_frame_start (i_frame_start),
        .o_push        (w_push),
        .o_frame       (w_frm_in)
    );

    ptrp_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_frame (w_frm_in),
        .i_pop   (w_pop),
        .o_frame (w_frm_out),
        .o_empty (w_empty),
        .o_full  (w_full)
    );

    ptrp_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_frame        (w_frm_out),
        .i_empty        (w_empty),
        .o_pop          (w_pop),
        .o_res_valid    (o_res_valid),
        .i_res_stall    (i_res_stall),
        .o_checksum_ok  (o_checksum_ok),
        .o_tag_detected (o_tag_detected),
        .o_pos_x        (o_pos_x),
        .o_pos_y        (o_pos_y),
        .o_heading      (o_heading),
        .o_tag_number   (o_tag_number)
    );

endmodule

`default_nettype wire

[hdl/ptrp_checker.sv]
// Port-level checks for the position tag response parser, bound to the top level.
`default_nettype none

module ptrp_checker (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_rx_valid,
    input  wire                  o_rx_stall,
    input  wire  [7:0]           i_rx_byte,
    input  wire                  i_frame_start,
    input  wire                  i_cfg_we,
    input  wire  [12:0]          i_cfg_data,
    input  wire                  o_res_valid,
    input  wire                  i_res_stall,
    input  wire                  o_checksum_ok,
    input  wire                  o_tag_detected,
    input  wire  [23:0]          o_pos_x,
    input  wire  [13:0]          o_pos_y,
    input  wire  [11:0]          o_heading,
    input  wire  [23:0]          o_tag_number
);

    // a held result stays valid and keeps its heading and x position
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && i_res_stall |=> o_res_valid && $stable(o_heading) && $stable(o_pos_x))
        else $error("result word changed while stalled");

    a_det_needs_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && !o_checksum_ok |-> !o_tag_detected)
        else $error("tag detected with bad checksum");

    a_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && !o_tag_detected |->
            o_pos_x == '0 && o_pos_y == '0 && o_heading == '0 && o_tag_number == '0)
        else $error("nonzero fields without a tag");

    a_heading_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> $signed(o_heading) > -12'sd1800 && $signed(o_heading) <= 12'sd1800)
        else $error("heading outside half turn");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_res_valid && !o_rx_stall)
        else $error("output active after reset");

endmodule

bind position_tag_response_parser ptrp_checker u_ptrp_checker (.*);

`default_nettype wire

[tb/tb.sv]
// Testbench for position_tag_response_parser: byte stream stimulus, result predictor, checks.
`timescale 1ns / 100ps

module tb;

    localparam int FRAME_LEN   = 21;
    localparam int STORE_LEN   = ptrp_pkg::SumLen;
    localparam int TURN        = 3600;
    localparam int HALF_TURN   = 1800;
    localparam int DET_BIT     = ptrp_pkg::DetBit;
    localparam int DRAIN       = 12;
    localparam int HOLD_CYCLES = 400;
    localparam int PHASE_BYTES = 180;
    localparam int N_PHASES    = 7;
    localparam int CYCLE_LIMIT = 400000;
    localparam int N_DIR       = 13;

    typedef enum int {FLOW, ALTERNATE, COIN, CHOKE} stall_mode_t;

    typedef struct packed {
        logic        ok;
        logic        det;
        logic [23:0] x;
        logic [13:0] y;
        logic [11:0] hd;
        logic [23:0] tag;
    } parse_res_t;

    typedef struct packed {
        logic [7:0]  hdr;
        logic [23:0] x;
        logic [13:0] y;
        logic [13:0] ang;
        logic [23:0] tag;
        logic [7:0]  flip;        // xor into checksum byte
        logic [7:0]  pad;         // unused bits and filler bytes
        logic [4:0]  restart_len; // partial frame sent first, 0 = none
        logic        no_start;
        logic        typed;
        parse_res_t  res;
    } frame_row_t;

    logic        i_clk;
    logic        rst_n       = 1'b0;
    logic        rx_valid    = 1'b0;
    logic [7:0]  rx_byte     = 8'h00;
    logic        rx_start    = 1'b0;
    logic        cfg_we      = 1'b0;
    logic [12:0] cfg_data    = 13'd0;
    logic        res_stall   = 1'b0;
    logic        typed_on    = 1'b0;
    parse_res_t  typed_val   = '0;

    wire                o_rx_stall;
    wire                o_res_valid;
    wire                o_checksum_ok;
    wire                o_tag_detected;
    wire signed [23:0]  o_pos_x;
    wire signed [13:0]  o_pos_y;
    wire signed [11:0]  o_heading;
    wire [23:0]         o_tag_number;

    position_tag_response_parser DUT (
        .i_clk          (i_clk),
        .i_rst_n        (rst_n),
        .i_rx_valid     (rx_valid),
        .o_rx_stall     (o_rx_stall),
        .i_rx_byte      (rx_byte),
        .i_frame_start  (rx_start),
        .i_cfg_we       (cfg_we),
        .i_cfg_data     (cfg_data),
        .o_res_valid    (o_res_valid),
        .i_res_stall    (res_stall),
        .o_checksum_ok  (o_checksum_ok),
        .o_tag_detected (o_tag_detected),
        .o_pos_x        (o_pos_x),
        .o_pos_y        (o_pos_y),
        .o_heading      (o_heading),
        .o_tag_number   (o_tag_number)
    );

    // parser model state
    int                 rx_count = 0;
    logic [7:0]         rx_xor = 8'h00;
    logic [7:0]         rx_store [STORE_LEN];
    logic signed [12:0] offset_model = 13'sd0;

    parse_res_t pending_results [$];
    int         mismatches = 0;
    int         cycle_count = 0;
    int         bytes_sent = 0;
    int         burst_left = 0;
    bit         hold_req = 0;
    logic [7:0] fb [FRAME_LEN];
    frame_row_t dir_rows [N_DIR];

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic bit parse_rx_byte(input logic [7:0] b, input logic fs,
                                         output parse_res_t r);
        logic signed [13:0] ang14;
        int d;
        r = '0;
        if (fs) begin
            rx_count = 0;
            rx_xor = 8'h00;
        end
        if (rx_count < STORE_LEN) begin
            rx_store[rx_count] = b;
            rx_xor ^= b;
            rx_count++;
            return 1'b0;
        end
        r.ok  = (rx_xor == b);
        r.det = r.ok && rx_store[1][DET_BIT];
        if (r.det) begin
            r.x = {rx_store[2][2:0], rx_store[3][6:0], rx_store[4][6:0], rx_store[5][6:0]};
            r.y = {rx_store[6][6:0], rx_store[7][6:0]};
            ang14 = {rx_store[10][6:0], rx_store[11][6:0]};
            d = int'(ang14) - int'(offset_model);
            d = d % TURN;
            if (d < 0) begin
                d += TURN;
            end
            if (d > HALF_TURN) begin
                d -= TURN;
            end
            r.hd = 12'(d);
            r.tag = {rx_store[14][2:0], rx_store[15][6:0], rx_store[16][6:0],
                     rx_store[17][6:0]};
        end
        rx_count = 0;
        rx_xor = 8'h00;
        return 1'b1;
    endfunction

    // input side: predict on every accepted word
    always @(posedge i_clk) begin : rx_side
        parse_res_t r;
        if (rst_n && rx_valid && !o_rx_stall) begin
            if (parse_rx_byte(rx_byte, rx_start, r)) begin
                pending_results.insert(pending_results.size(), typed_on ? typed_val : r);
            end
        end
    end

    // result side: compare against the oldest expectation
    always @(posedge i_clk) begin : res_side
        parse_res_t got, want;
        if (rst_n && o_res_valid && !res_stall) begin
            got = {o_checksum_ok, o_tag_detected, o_pos_x, o_pos_y, o_heading, o_tag_number};
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected result: ok=%0d det=%0d x=%h y=%h hd=%h tag=%h",
                             got.ok, got.det, got.x, got.y, got.hd, got.tag);
                end
            end else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("result mismatch: exp ok=%0d det=%0d x=%h y=%h hd=%h tag=%h",
                                 want.ok, want.det, want.x, want.y, want.hd, want.tag);
                        $display("                 got ok=%0d det=%0d x=%h y=%h hd=%h tag=%h",
                                 got.ok, got.det, got.x, got.y, got.hd, got.tag);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("position_tag_response_parser regression: fail");
            $finish;
        end
    end

    // receiver: stall patterns, plus one long hold-off to back up the queue
    initial begin : receiver
        int run_len;
        stall_mode_t mode;
        bit hold_done;
        hold_done = 0;
        @(posedge i_clk);
        while (!rst_n) @(posedge i_clk);
        forever begin
            if (hold_req && !hold_done) begin
                hold_done = 1;
                res_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            run_len = $urandom_range(1, 30);
            mode = stall_mode_t'($urandom_range(0, 3));
            for (int k = 0; k < run_len; k++) begin
                case (mode)
                    FLOW:      res_stall <= 1'b0;
                    ALTERNATE: res_stall <= k[0];
                    COIN:      res_stall <= 1'($urandom_range(0, 1));
                    default:   res_stall <= ($urandom_range(0, 3) != 0);
                endcase
                @(posedge i_clk);
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic fs, input bit typed,
                             input parse_res_t tres);
        int gap;
        rx_valid  <= 1'b1;
        rx_byte   <= b;
        rx_start  <= fs;
        typed_on  <= typed;
        typed_val <= tres;
        @(posedge i_clk);
        while (o_rx_stall) @(posedge i_clk);
        bytes_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(0, 30);
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 4);
            rx_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic build_frame(input logic [7:0] hdr, input logic [23:0] x,
                               input logic [13:0] y, input logic [13:0] ang,
                               input logic [23:0] tag, input logic [7:0] flip,
                               input bit rnd_pad, input logic [7:0] pad);
        logic [7:0] sum;
        for (int i = 0; i < FRAME_LEN; i++) begin
            fb[i] = rnd_pad ? 8'($urandom) : pad;
        end
        fb[1] = hdr;
        fb[2][2:0]  = x[23:21];
        fb[3][6:0]  = x[20:14];
        fb[4][6:0]  = x[13:7];
        fb[5][6:0]  = x[6:0];
        fb[6][6:0]  = y[13:7];
        fb[7][6:0]  = y[6:0];
        fb[10][6:0] = ang[13:7];
        fb[11][6:0] = ang[6:0];
        fb[14][2:0] = tag[23:21];
        fb[15][6:0] = tag[20:14];
        fb[16][6:0] = tag[13:7];
        fb[17][6:0] = tag[6:0];
        sum = 8'h00;
        for (int i = 0; i < STORE_LEN; i++) begin
            sum ^= fb[i];
        end
        fb[20] = sum ^ flip;
    endtask

    task automatic send_frame(input logic fs, input bit typed, input parse_res_t tres);
        for (int i = 0; i < FRAME_LEN; i++) begin
            send_byte(fb[i], (i == 0) ? fs : 1'b0, typed && (i == FRAME_LEN - 1), tres);
        end
    endtask

    // truncated response: first word flagged, rest random
    task automatic send_partial(input int n);
        for (int i = 0; i < n; i++) begin
            send_byte(8'($urandom), (i == 0), 1'b0, '0);
        end
    endtask

    task automatic wait_idle();
        rx_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    task automatic write_offset(input int v);
        cfg_we   <= 1'b1;
        cfg_data <= 13'(v);
        @(posedge i_clk);
        offset_model = 13'(v);
        cfg_we <= 1'b0;
    endtask

    task automatic random_chunk();
        int kind;
        logic [7:0]  hdr;
        logic [23:0] x, tag;
        logic [13:0] y, ang;
        logic [7:0]  flip;
        logic [23:0] x_corner [4];
        logic [13:0] ang_corner [7];
        x_corner   = '{24'h7FFFFF, 24'h800000, 24'h000000, 24'hFFFFFF};
        ang_corner = '{14'(1800), 14'(1801), 14'(-1800), 14'(-1799), 14'h1FFF, 14'h2000, 14'd0};
        kind = $urandom_range(0, 99);
        hdr = 8'($urandom);
        hdr[DET_BIT] = ($urandom_range(0, 4) != 0);
        x   = ($urandom_range(0, 9) == 0) ? x_corner[$urandom_range(0, 3)] : 24'($urandom);
        y   = 14'($urandom);
        ang = ($urandom_range(0, 4) == 0) ? ang_corner[$urandom_range(0, 6)] : 14'($urandom);
        tag = ($urandom_range(0, 9) == 0) ? x_corner[$urandom_range(0, 3)] : 24'($urandom);
        flip = (kind >= 70 && kind < 80) ? 8'($urandom_range(1, 255)) : 8'h00;
        build_frame(hdr, x, y, ang, tag, flip, 1'b1, 8'h00);
        if (kind < 80) begin
            send_frame(1'b1, 1'b0, '0);
        end else if (kind < 88) begin
            send_partial($urandom_range(1, STORE_LEN));
            send_frame(1'b1, 1'b0, '0);
        end else if (kind < 94) begin
            send_frame(1'b0, 1'b0, '0);
        end else begin
            repeat ($urandom_range(1, 30)) begin
                send_byte(8'($urandom), ($urandom_range(0, 9) == 0), 1'b0, '0);
            end
        end
    endtask

    initial begin : stimulus
        frame_row_t row;
        int target;
        int ofs;
        // hdr, x, y, ang, tag, flip, pad, restart_len, no_start, typed, expected
        dir_rows[0]  = '{8'h00, 24'h000000, 14'h0000, 14'd0, 24'h000000, 8'h00, 8'h00,
                         5'd0, 1'b0, 1'b1, '{1'b1, 1'b0, 24'h0, 14'h0, 12'h0, 24'h0}};
        dir_rows[1]  = '{8'h40, 24'h7FFFFF, 14'h1FFF, 14'd0, 24'hFFFFFF, 8'h00, 8'hFF,
                         5'd0, 1'b0, 1'b1,
                         '{1'b1, 1'b1, 24'h7FFFFF, 14'h1FFF, 12'd0, 24'hFFFFFF}};
        dir_rows[2]  = '{8'h40, 24'h800000, 14'h2000, 14'd1800, 24'h000000, 8'h00, 8'h00,
                         5'd0, 1'b0, 1'b1,
                         '{1'b1, 1'b1, 24'h800000, 14'h2000, 12'd1800, 24'h000000}};
        dir_rows[3]  = '{8'hFF, 24'h123456, 14'h0ABC, 14'(-1800), 24'hABCDEF, 8'h00, 8'h80,
                         5'd0, 1'b0, 1'b0, '0};
        dir_rows[4]  = '{8'h40, 24'hFFFFFF, 14'h3FFF, 14'(1801), 24'h555555, 8'h00, 8'h00,
                         5'd0, 1'b0, 1'b0, '0};
        dir_rows[5]  = '{8'h40, 24'h000001, 14'h0001, 14'h1FFF, 24'h000001, 8'h00, 8'hFF,
                         5'd0, 1'b0, 1'b0, '0};
        dir_rows[6]  = '{8'h40, 24'hAAAAAA, 14'h2AAA, 14'h2000, 24'hAAAAAA, 8'h00, 8'h00,
                         5'd0, 1'b0, 1'b0, '0};
        // bad checksum: flagged result, values cleared
        dir_rows[7]  = '{8'h40, 24'h7FFFFF, 14'h1FFF, 14'd100, 24'hFFFFFF, 8'h01, 8'h00,
                         5'd0, 1'b0, 1'b1, '{1'b0, 1'b0, 24'h0, 14'h0, 12'h0, 24'h0}};
        dir_rows[8]  = '{8'hFF, 24'h654321, 14'h1234, 14'd900, 24'h123456, 8'h80, 8'hFF,
                         5'd0, 1'b0, 1'b1, '{1'b0, 1'b0, 24'h0, 14'h0, 12'h0, 24'h0}};
        // detect bit clear, every other header bit set
        dir_rows[9]  = '{8'hBF, 24'h7FFFFF, 14'h1FFF, 14'd500, 24'hFFFFFF, 8'h00, 8'hFF,
                         5'd0, 1'b0, 1'b1, '{1'b1, 1'b0, 24'h0, 14'h0, 12'h0, 24'h0}};
        dir_rows[10] = '{8'h40, 24'h0F0F0F, 14'h0F0F, 14'd3599, 24'hF0F0F0, 8'h00, 8'h00,
                         5'd7, 1'b0, 1'b0, '0};
        dir_rows[11] = '{8'h40, 24'h300000, 14'h1000, 14'(-3599), 24'h0000FF, 8'h00, 8'h00,
                         5'd0, 1'b1, 1'b0, '0};
        dir_rows[12] = '{8'h40, 24'h400000, 14'h0800, 14'd1, 24'hFF0000, 8'h00, 8'h7F,
                         5'd20, 1'b0, 1'b0, '0};

        repeat (9) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < N_DIR; i++) begin
            row = dir_rows[i];
            build_frame(row.hdr, row.x, row.y, row.ang, row.tag, row.flip, 1'b0, row.pad);
            if (row.restart_len != 0) begin
                send_partial(int'(row.restart_len));
            end
            send_frame(!row.no_start, row.typed, row.res);
        end

        for (int ph = 0; ph < N_PHASES; ph++) begin
            case (ph)
                0:       ofs = 3600;
                1:       ofs = -3600;
                2:       ofs = 1;
                3:       ofs = -1;
                5:       ofs = 0;
                default: ofs = int'($urandom_range(0, 7200)) - 3600;
            endcase
            wait_idle();
            write_offset(ofs);
            if (ph == 1) begin
                hold_req = 1;
            end
            target = bytes_sent + PHASE_BYTES;
            while (bytes_sent < target) random_chunk();
        end

        wait_idle();
        repeat (DRAIN) @(posedge i_clk);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("position_tag_response_parser regression: pass");
        end else begin
            $display("position_tag_response_parser regression: fail");
        end
        $finish;
    end

endmodule
